// ----- rtl/core/h264nf_pkg.sv -----
// Package for the H.264 Annex B unit filter: payload types, burst record and constants.
package h264nf_pkg;

   localparam int ByteW = 8;
   localparam int TypeW = 5;
   localparam int MaskW = 32;
   localparam int ZeroCntW = 3;

   localparam logic [MaskW-1:0] DropMaskReset = 32'h0000_1240;
   localparam logic PpsNeedsSpsReset = 1'b1;

   localparam logic [TypeW-1:0] NalSps = 5'd7;
   localparam logic [TypeW-1:0] NalPps = 5'd8;

   localparam logic [ByteW-1:0] ByteZero = 8'h00;
   localparam logic [ByteW-1:0] ByteOne  = 8'h01;

   typedef enum logic {
      CSR_DROP_TYPE_MASK = 1'b0,
      CSR_PPS_NEEDS_SPS  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_SEARCH = 2'd0,
      PH_UNIT   = 2'd1,
      PH_HEADER = 2'd2
   } phase_type;

   typedef struct packed {
      logic [ByteW-1:0] in_byte;
      logic             frame_last;
   } req_type;

   typedef struct packed {
      logic [ByteW-1:0] out_byte;
      logic             has_byte;
      logic             run_last;
      logic             frame_end;
      logic             frame_empty;
   } rsp_type;

   // Results of one request: some zeros, then an optional 01, then an optional
   // final byte, or a single byteless result that only marks the frame end.
   typedef struct packed {
      logic                load;
      logic [ZeroCntW-1:0] zeros;
      logic                one;
      logic                tail;
      logic [ByteW-1:0]    tail_byte;
      logic                blank;
      logic                frame_end;
      logic                frame_empty;
   } burst_type;

endpackage

// ----- rtl/core/h264_nal_unit_filter_top.sv -----
// Top level of the H.264 Annex B unit filter.
//
// One frame byte enters per request on req_*, with frame_last on the final
// byte of the frame. The filter finds start codes, removes unwanted units and
// sends the kept stream on rsp_*, at most one byte per result. The csr_* port sets the
// drop type mask (index 0) and the PPS-needs-SPS rule (index 1); write it only
// while the block is idle.
// A request takes effect in the cycle it is accepted; its first result shows
// on rsp_* in the next cycle. A request gives zero to five results, sent one
// per cycle from a single result register while the receiver takes them. A
// request is taken every cycle while each gives at most one result and the
// receiver takes it; one that gives more holds req_ready low as the register
// drains, until its last result is taken. Requests that give no result pass
// without a gap. The frame end always gives a result, with has_byte low when
// no byte came out in that request. Reset clears the parse state and loads the
// register defaults. When the receiver stalls, the current result holds and
// req_ready stays low until the last result of the held burst is taken.
module h264_nal_unit_filter_top
   import h264nf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [MaskW-1:0] csr_wdata
);

   burst_type burst;
   logic      req_accept;

   assign req_accept = req_valid && req_ready;

   h264nf_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_accept (req_accept),
      .req_data   (req_data),
      .burst      (burst)
   );

   h264nf_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .burst     (burst),
      .free      (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/core/h264nf_parse.sv -----
// Start code parser and unit filter: per-request state update and result burst build.
module h264nf_parse
   import h264nf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [MaskW-1:0]  csr_wdata,
   input  logic              req_accept,
   input  req_type           req_data,
   output burst_type         burst
);

   logic [MaskW-1:0]    drop_mask_ff;
   logic                pps_needs_sps_ff;

   phase_type           phase_ff, phase_in;
   logic [1:0]          pz_ff, pz_in;
   logic                long_ff, long_in;
   logic                keep_ff, keep_in;
   logic                sps_ff, sps_in;
   logic                any_ff, any_in;

   logic [TypeW-1:0]    hdr_type;
   logic                hdr_keep;
   logic                is_zero;
   logic                start_hit;
   logic [ZeroCntW-1:0] nz;
   logic                one;
   logic                tail;
   logic                has_bytes;

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_mask_ff     <= DropMaskReset;
         pps_needs_sps_ff <= PpsNeedsSpsReset;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DROP_TYPE_MASK: drop_mask_ff     <= csr_wdata;
            CSR_PPS_NEEDS_SPS:  pps_needs_sps_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         pz_ff    <= '0;
         long_ff  <= 1'b0;
         keep_ff  <= 1'b0;
         sps_ff   <= 1'b0;
         any_ff   <= 1'b0;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         pz_ff    <= pz_in;
         long_ff  <= long_in;
         keep_ff  <= keep_in;
         sps_ff   <= sps_in;
         any_ff   <= any_in;
      end
   end

   assign hdr_type  = req_data.in_byte[TypeW-1:0];
   assign hdr_keep  = !drop_mask_ff[hdr_type] &&
                      !(hdr_type == NalPps && pps_needs_sps_ff && !sps_ff);
   assign is_zero   = (req_data.in_byte == ByteZero);
   // Two or more held zeros followed by 01 complete a start code.
   assign start_hit = (req_data.in_byte == ByteOne) && pz_ff[1];

   always_comb begin
      phase_in = phase_ff;
      pz_in    = pz_ff;
      long_in  = long_ff;
      keep_in  = keep_ff;
      sps_in   = sps_ff;
      nz       = '0;
      one      = 1'b0;
      tail     = 1'b0;

      unique case (phase_ff)
         PH_HEADER: begin
            if (hdr_type == NalSps) begin
               sps_in = 1'b1;
            end
            if (hdr_keep) begin
               nz   = long_ff ? ZeroCntW'(3) : ZeroCntW'(2);
               one  = 1'b1;
               tail = 1'b1;
            end
            keep_in  = hdr_keep;
            phase_in = PH_UNIT;
            pz_in    = '0;
         end
         PH_UNIT: begin
            if (is_zero) begin
               // A fourth zero in a row pushes the oldest one out as unit data.
               if (pz_ff == 2'd3) begin
                  nz = keep_ff ? ZeroCntW'(1) : '0;
               end else begin
                  pz_in = pz_ff + 2'd1;
               end
            end else if (start_hit) begin
               long_in  = (pz_ff == 2'd3);
               pz_in    = '0;
               phase_in = PH_HEADER;
            end else begin
               if (keep_ff) begin
                  nz   = ZeroCntW'(pz_ff);
                  tail = 1'b1;
               end
               pz_in = '0;
            end
         end
         default: begin
            if (is_zero) begin
               if (pz_ff != 2'd3) begin
                  pz_in = pz_ff + 2'd1;
               end
            end else if (start_hit) begin
               long_in  = (pz_ff == 2'd3);
               pz_in    = '0;
               phase_in = PH_HEADER;
            end else begin
               pz_in = '0;
            end
         end
      endcase

      // Zeros still held at frame end belong to the open unit.
      if (req_data.frame_last && phase_in == PH_UNIT && keep_in) begin
         nz = nz + ZeroCntW'(pz_in);
      end

      has_bytes = (nz != '0) || one || tail;
      any_in    = any_ff || has_bytes;

      burst.load        = req_accept && (has_bytes || req_data.frame_last);
      burst.zeros       = nz;
      burst.one         = one;
      burst.tail        = tail;
      burst.tail_byte   = req_data.in_byte;
      burst.blank       = !has_bytes;
      burst.frame_end   = req_data.frame_last;
      burst.frame_empty = !any_in;

      if (req_data.frame_last) begin
         phase_in = PH_SEARCH;
         pz_in    = '0;
         long_in  = 1'b0;
         keep_in  = 1'b0;
         sps_in   = 1'b0;
         any_in   = 1'b0;
      end
   end

endmodule

// ----- rtl/core/h264nf_serial.sv -----
// Result register that holds one request's burst and sends it out one result per cycle while rsp_ready is high.
module h264nf_serial
   import h264nf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  burst_type burst,
   output logic      free,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   logic                busy_ff, busy_in;
   logic [ZeroCntW-1:0] zeros_ff, zeros_in;
   logic                one_ff, one_in;
   logic                tail_ff, tail_in;
   logic [ByteW-1:0]    tail_byte_ff, tail_byte_in;
   logic                blank_ff, blank_in;
   logic                frame_end_ff, frame_end_in;
   logic                frame_empty_ff, frame_empty_in;

   logic [ZeroCntW-1:0] remaining;
   logic                final_one;
   logic                take;

   assign remaining = zeros_ff + ZeroCntW'(one_ff) + ZeroCntW'(tail_ff) + ZeroCntW'(blank_ff);
   assign final_one = (remaining == ZeroCntW'(1));
   assign take      = busy_ff && rsp_ready;
   assign free      = !busy_ff || (take && final_one);
   assign rsp_valid = busy_ff;

   always_comb begin
      rsp_data.has_byte = 1'b1;
      if (zeros_ff != '0) begin
         rsp_data.out_byte = ByteZero;
      end else if (one_ff) begin
         rsp_data.out_byte = ByteOne;
      end else if (tail_ff) begin
         rsp_data.out_byte = tail_byte_ff;
      end else begin
         rsp_data.out_byte = ByteZero;
         rsp_data.has_byte = 1'b0;
      end
      rsp_data.run_last    = final_one;
      rsp_data.frame_end   = final_one && frame_end_ff;
      rsp_data.frame_empty = final_one && frame_end_ff && frame_empty_ff;
   end

   always_comb begin
      busy_in        = busy_ff;
      zeros_in       = zeros_ff;
      one_in         = one_ff;
      tail_in        = tail_ff;
      tail_byte_in   = tail_byte_ff;
      blank_in       = blank_ff;
      frame_end_in   = frame_end_ff;
      frame_empty_in = frame_empty_ff;

      if (take) begin
         if (zeros_ff != '0) begin
            zeros_in = zeros_ff - ZeroCntW'(1);
         end else if (one_ff) begin
            one_in = 1'b0;
         end else if (tail_ff) begin
            tail_in = 1'b0;
         end else begin
            blank_in = 1'b0;
         end
         if (final_one) begin
            busy_in = 1'b0;
         end
      end

      // A new burst is only loaded when the held one is gone or leaving now.
      if (burst.load) begin
         busy_in        = 1'b1;
         zeros_in       = burst.zeros;
         one_in         = burst.one;
         tail_in        = burst.tail;
         tail_byte_in   = burst.tail_byte;
         blank_in       = burst.blank;
         frame_end_in   = burst.frame_end;
         frame_empty_in = burst.frame_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         zeros_ff <= '0;
         one_ff   <= 1'b0;
         tail_ff  <= 1'b0;
         blank_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         zeros_ff <= zeros_in;
         one_ff   <= one_in;
         tail_ff  <= tail_in;
         blank_ff <= blank_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_byte_ff   <= tail_byte_in;
      frame_end_ff   <= frame_end_in;
      frame_empty_ff <= frame_empty_in;
   end

endmodule

// ----- dv/h264_nal_unit_filter_top_tb.sv -----
// Self-checking testbench for the H.264 Annex B unit filter top level.
`timescale 1ns / 1ps

module h264_nal_unit_filter_top_tb;
   import h264nf_pkg::*;

   localparam int CycleLimit = 200_000;
   localparam int HoldCycles = 120;
   localparam int MaxReports = 10;

   localparam logic [TypeW-1:0] NalSlice  = 5'd1;
   localparam logic [TypeW-1:0] NalIdr    = 5'd5;
   localparam logic [TypeW-1:0] NalSei    = 5'd6;
   localparam logic [TypeW-1:0] NalAud    = 5'd9;
   localparam logic [TypeW-1:0] NalFiller = 5'd12;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we = 1'b0;
   logic             csr_index = 1'b0;
   logic [MaskW-1:0] csr_wdata = '0;

   // Filter model state and its copy of the registers.
   logic [MaskW-1:0] drop_mask;
   logic             pps_rule;
   phase_type        phase;
   int               held_zeros;
   logic             long_sc;
   logic             keep_unit;
   logic             sps_seen;
   logic             any_out;

   rsp_type          expected_stream[$];
   logic [ByteW-1:0] frame_bytes[$];
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               errors = 0;
   int               cycle_count = 0;
   logic             stall_trigger = 1'b0;
   logic             stall_seen = 1'b0;
   int               stall_left = 0;

   h264_nal_unit_filter_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("h264_nal_unit_filter_top_tb failed");
         $finish;
      end
   end

   // Works out the stream bytes that one accepted request puts out.
   function automatic void predict_filter(req_type r);
      logic [ByteW-1:0] outq[$];
      logic [TypeW-1:0] unit_kind;
      logic             keep;
      logic             blank;
      logic             start_found;
      rsp_type          res;
      blank = 1'b0;
      start_found = (r.in_byte == ByteOne) && (held_zeros >= 2);
      if (phase == PH_HEADER) begin
         unit_kind = r.in_byte[TypeW-1:0];
         if (unit_kind == NalSps) sps_seen = 1'b1;
         keep = !drop_mask[unit_kind];
         if (unit_kind == NalPps && pps_rule && !sps_seen) keep = 1'b0;
         if (keep) begin
            if (long_sc) outq.push_back(ByteZero);
            outq.push_back(ByteZero);
            outq.push_back(ByteZero);
            outq.push_back(ByteOne);
            outq.push_back(r.in_byte);
         end
         keep_unit = keep;
         phase = PH_UNIT;
         held_zeros = 0;
      end else if (r.in_byte == ByteZero) begin
         if (held_zeros < 3) begin
            held_zeros++;
         end else if (phase == PH_UNIT && keep_unit) begin
            // The oldest held zero is pushed out as unit data.
            outq.push_back(ByteZero);
         end
      end else if (start_found) begin
         long_sc = (held_zeros >= 3);
         held_zeros = 0;
         phase = PH_HEADER;
      end else begin
         if (phase == PH_UNIT && keep_unit) begin
            repeat (held_zeros) outq.push_back(ByteZero);
            outq.push_back(r.in_byte);
         end
         held_zeros = 0;
      end

      if (r.frame_last && phase == PH_UNIT && keep_unit)
         repeat (held_zeros) outq.push_back(ByteZero);
      if (outq.size() != 0) any_out = 1'b1;

      if (outq.size() == 0) begin
         if (!r.frame_last) return;
         blank = 1'b1;
         outq.push_back(ByteZero);
      end
      foreach (outq[i]) begin
         res.out_byte    = outq[i];
         res.has_byte    = !blank;
         res.run_last    = (i == outq.size() - 1);
         res.frame_end   = res.run_last && r.frame_last;
         res.frame_empty = res.frame_end && !any_out;
         expected_stream.push_back(res);
      end

      if (r.frame_last) begin
         phase = PH_SEARCH;
         held_zeros = 0;
         long_sc = 1'b0;
         keep_unit = 1'b0;
         sps_seen = 1'b0;
         any_out = 1'b0;
      end
   endfunction

   function automatic void check_stream_result(rsp_type got);
      rsp_type want;
      if (expected_stream.size() == 0) begin
         if (errors < MaxReports)
            $display("unexpected result: byte %h has %b run_last %b frame_end %b empty %b",
                     got.out_byte, got.has_byte, got.run_last, got.frame_end,
                     got.frame_empty);
         errors++;
         return;
      end
      want = expected_stream.pop_front();
      if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
          got.run_last !== want.run_last || got.frame_end !== want.frame_end ||
          got.frame_empty !== want.frame_empty) begin
         if (errors < MaxReports) begin
            $display("mismatch: expected byte %h has %b run_last %b frame_end %b empty %b",
                     want.out_byte, want.has_byte, want.run_last, want.frame_end,
                     want.frame_empty);
            $display("          actual   byte %h has %b run_last %b frame_end %b empty %b",
                     got.out_byte, got.has_byte, got.run_last, got.frame_end,
                     got.frame_empty);
         end
         errors++;
      end
   endfunction

   // Counts out the long receiver hold-off that the back-pressure test asks for.
   always @(posedge clock) begin
      if (stall_trigger != stall_seen) begin
         stall_seen <= stall_trigger;
         stall_left <= HoldCycles;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // Result side: checks each accepted result and drives rsp_ready.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_stream_result(rsp_data);
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
      req_type r;
      r.in_byte = b;
      r.frame_last = last;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predict_filter(r);
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_stream.size() != 0) @(posedge clock);
      // A request that gives no result may still be in flight.
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [MaskW-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_DROP_TYPE_MASK) drop_mask = value;
      else pps_rule = value[0];
   endtask

   function automatic logic [ByteW-1:0] data_byte();
      case ($urandom_range(9))
         0, 1, 2, 3: return ByteZero;
         4:          return ByteOne;
         5:          return 8'h03;
         default:    return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [ByteW-1:0] header_byte();
      logic [ByteW-1:0] hdr;
      hdr = 8'($urandom_range(255));
      case ($urandom_range(7))
         0:       hdr[TypeW-1:0] = NalSlice;
         1:       hdr[TypeW-1:0] = NalIdr;
         2:       hdr[TypeW-1:0] = NalSei;
         3:       hdr[TypeW-1:0] = NalSps;
         4:       hdr[TypeW-1:0] = NalPps;
         5:       hdr[TypeW-1:0] = NalAud;
         6:       hdr[TypeW-1:0] = NalFiller;
         default: ;
      endcase
      return hdr;
   endfunction

   // Mostly well-formed frames of a few units with random content; some noise.
   task automatic build_random_frame();
      frame_bytes.delete();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 10)) frame_bytes.push_back(data_byte());
      end else begin
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(data_byte());
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(1) == 1) frame_bytes.push_back(ByteZero);
            frame_bytes.push_back(ByteZero);
            frame_bytes.push_back(ByteZero);
            frame_bytes.push_back(ByteOne);
            if ($urandom_range(11) != 0) frame_bytes.push_back(header_byte());
            repeat ($urandom_range(0, 6)) frame_bytes.push_back(data_byte());
         end
      end
   endtask

   task automatic run_random_phase(input int n_items);
      int sent;
      sent = 0;
      while (sent < n_items) begin
         build_random_frame();
         send_frame();
         sent += frame_bytes.size();
      end
      wait_until_idle();
   endtask

   // Junk before the first start code, zero saturation while searching, a long
   // start code, a zero pushed out by a run of four, zeros flushed at frame end,
   // a PPS with and without an SPS, a zero header, a dangling start code and a
   // frame that gives no byte.
   task automatic test_directed();
      frame_bytes = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h01, 8'h68, 8'h00};
      send_frame();
      frame_bytes = '{8'h00, 8'h00, 8'h01, 8'h08, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
                      8'h01, 8'h00, 8'h00, 8'h01};
      send_frame();
      frame_bytes = '{8'h00};
      send_frame();
      wait_until_idle();
   endtask

   task automatic test_register_extremes();
      frame_bytes = '{8'h00, 8'h00, 8'h01, 8'h08, 8'hAB, 8'h00, 8'h00, 8'h01, 8'h06,
                      8'hCD, 8'h00, 8'h00, 8'h01, 8'h09};
      write_csr(CSR_DROP_TYPE_MASK, '0);
      write_csr(CSR_PPS_NEEDS_SPS, '0);
      send_frame();
      wait_until_idle();
      write_csr(CSR_DROP_TYPE_MASK, '1);
      write_csr(CSR_PPS_NEEDS_SPS, 32'd1);
      send_frame();
      wait_until_idle();
      write_csr(CSR_DROP_TYPE_MASK, '0);
      send_frame();
      wait_until_idle();
   endtask

   task automatic test_random_traffic();
      write_csr(CSR_DROP_TYPE_MASK, DropMaskReset);
      write_csr(CSR_PPS_NEEDS_SPS, 32'(PpsNeedsSpsReset));
      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_random_phase(4);

      write_csr(CSR_DROP_TYPE_MASK, 32'($urandom()));
      write_csr(CSR_PPS_NEEDS_SPS, '0);
      send_idle_pct = 58;
      run_random_phase(4);

      write_csr(CSR_DROP_TYPE_MASK, '0);
      write_csr(CSR_PPS_NEEDS_SPS, 32'd1);
      send_idle_pct = 0;
      recv_stall_pct = 58;
      run_random_phase(4);

      write_csr(CSR_DROP_TYPE_MASK, DropMaskReset | 32'($urandom_range(255)));
      write_csr(CSR_PPS_NEEDS_SPS, 32'($urandom_range(1)));
      send_idle_pct = 35;
      recv_stall_pct = 35;
      run_random_phase(4);
   endtask

   // The receiver holds off while short kept units keep arriving, so the
   // result register fills and the block has to stall the request side.
   task automatic test_backpressure();
      write_csr(CSR_DROP_TYPE_MASK, DropMaskReset);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      frame_bytes.delete();
      repeat (6) begin
         frame_bytes.push_back(ByteZero);
         frame_bytes.push_back(ByteZero);
         frame_bytes.push_back(ByteOne);
         frame_bytes.push_back({3'b011, NalSlice});
         frame_bytes.push_back(8'($urandom_range(2, 255)));
      end
      stall_trigger = ~stall_trigger;
      send_frame();
      wait_until_idle();
   endtask

   initial begin
      drop_mask = DropMaskReset;
      pps_rule = PpsNeedsSpsReset;
      phase = PH_SEARCH;
      held_zeros = 0;
      long_sc = 1'b0;
      keep_unit = 1'b0;
      sps_seen = 1'b0;
      any_out = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_extremes();
      test_random_traffic();
      test_backpressure();

      repeat (8) @(posedge clock);
      if (errors == 0 && expected_stream.size() == 0) begin
         $display("h264_nal_unit_filter_top_tb passed");
      end else begin
         $display("h264_nal_unit_filter_top_tb failed");
      end
      $finish;
   end

endmodule
